// ----- hw/rtl/mgr_pkg.sv -----
// Shared types, constants and helper functions for the 3x3 morphological gradient.
// Used by the window cells, the line buffer, the output queue and the top level.
package mgr_pkg;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_MIN = '0;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 4'd0,
    CFG_FRAME_HEIGHT = 4'd1
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // One window column, index 0 is the top row and index 2 the bottom row.
  typedef logic [2:0][PIX_W-1:0] pix_col_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } line_pair_t;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
  } row_mask_t;

  typedef struct packed {
    logic flush;
    logic top_ok;
    logic emit_first;
    logic emit_second;
    logic all_cols;
    logic two_cols;
  } stage_ctrl_t;

  typedef struct packed {
    pixel_t gradient;
    logic   end_of_frame;
    logic   last_of_run;
  } result_t;

  function automatic pixel_t pix_max(pixel_t a, pixel_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pixel_t pix_min(pixel_t a, pixel_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- hw/rtl/mgr_cell.sv -----
// One column cell of the 3x3 window: holds three pixels and hands them on.
// Depends on mgr_pkg for the column, mask and min/max helpers.
module mgr_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  mgr_pkg::pix_col_t col_i,
  input  mgr_pkg::row_mask_t mask_i,
  output mgr_pkg::pix_col_t col_o,
  output mgr_pkg::pixel_t   max_o,
  output mgr_pkg::pixel_t   min_o
);
  import mgr_pkg::*;

  pix_col_t col_q;
  pixel_t   top_hi, top_lo, bot_hi, bot_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    top_hi = mask_i.top_ok ? col_q[0] : PIX_MIN;
    top_lo = mask_i.top_ok ? col_q[0] : PIX_MAX;
    bot_hi = mask_i.bot_ok ? col_q[2] : PIX_MIN;
    bot_lo = mask_i.bot_ok ? col_q[2] : PIX_MAX;
    max_o  = pix_max(pix_max(top_hi, col_q[1]), bot_hi);
    min_o  = pix_min(pix_min(top_lo, col_q[1]), bot_lo);
  end

  assign col_o = col_q;

endmodule

// ----- hw/rtl/mgr_line_buf.sv -----
// Line buffer holding the two rows above the incoming one, one entry per column.
// Registered read with write-to-read forwarding; depends on mgr_pkg.
module mgr_line_buf #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output mgr_pkg::line_pair_t      rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  mgr_pkg::line_pair_t      wr_data_i
);
  import mgr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  line_pair_t mem [DEPTH];
  line_pair_t rd_q;
  line_pair_t fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == AW'(rd_addr_i));
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ----- hw/rtl/mgr_out_fifo.sv -----
// Small result queue that takes up to two results a cycle and releases one.
// Depends on mgr_pkg for the result type and depth.
module mgr_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  mgr_pkg::result_t   push_first_i,
  input  mgr_pkg::result_t   push_second_i,
  input  logic               pop_i,
  output logic               valid_o,
  output mgr_pkg::result_t   head_o
);
  import mgr_pkg::*;

  result_t               mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0]  count_q, count_d;
  logic [OUT_PTR_W-1:0]  wr_ptr_next;
  logic                  pop;

  assign valid_o     = (count_q != '0);
  assign pop         = valid_o && pop_i;
  assign head_o      = mem_q[rd_ptr_q];
  assign wr_ptr_next = wr_ptr_q + OUT_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_PTR_W'(push_n_i);
    rd_ptr_d = rd_ptr_q + OUT_PTR_W'(pop);
    count_d  = count_q + OUT_CNT_W'(push_n_i) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_first_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_next] <= push_second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- hw/rtl/morph_gradient_3x3.sv -----
// Top level of the 3x3 grayscale morphological gradient; uses mgr_pkg, mgr_line_buf,
// mgr_cell and mgr_out_fifo. A raster-order pixel stream enters at one beat per
// cycle while in_stall_o is low, and each centre pixel leaves as window maximum
// minus window minimum, with out-of-frame neighbours left out. Results trail the
// input by one row and one column; the last row is drained by frame_width flush
// beats. An item's results are written into the output queue after the line buffer
// read and the shift into the window cells, both registered, with the min/max tree
// settling in front of the queue; a result on an empty queue is offered as soon as
// it is written.
// Past row 0 a row end yields two results, which the eight-entry output queue absorbs,
// so the input sustains one beat per cycle while the output is taken every cycle. The
// line buffer is not cleared after reset, so no clearing pass delays the first beat.
module morph_gradient_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [mgr_pkg::PIX_W-1:0]           pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mgr_pkg::PIX_W-1:0]           gradient_o,
  output logic                                end_of_frame_o,
  output logic                                last_of_run_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mgr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mgr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import mgr_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int W_RST = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [WIDTH_W-1:0]  col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;
  logic [OUT_CNT_W-1:0] pending_q, pending_d;

  logic                cfg_we;
  logic [WIDTH_W-1:0]  cfg_width;
  logic                take, is_flush, col_last, pop;
  logic [1:0]          n_res;
  stage_ctrl_t         ctrl0;

  logic                s1_valid_q, s2_valid_q;
  stage_ctrl_t         s1_ctrl_q, s2_ctrl_q;
  pixel_t              s1_px_q;
  logic [AW-1:0]       s1_addr_q;

  line_pair_t          lb_rd_data, lb_wr_data;
  logic                lb_wr_en;
  pix_col_t            new_col;
  row_mask_t           mask;
  pix_col_t            cell_col [3];
  pixel_t              cell_max [3];
  pixel_t              cell_min [3];

  pixel_t              hi_pair, lo_pair, hi_a, lo_a, g1, g2;
  result_t             res_first, res_second, push_first;
  logic [1:0]          push_n;
  result_t             head;

  // Configuration.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o &&
                       ((cfg_index_i == CFG_FRAME_WIDTH) || (cfg_index_i == CFG_FRAME_HEIGHT));
  assign cfg_width   = cfg_data_i[WIDTH_W-1:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_FRAME_WIDTH)) begin
      if (cfg_width == '0) begin
        width_d = WIDTH_W'(1);
      end else if (32'(cfg_width) > MAX_WIDTH) begin
        width_d = WIDTH_W'(MAX_WIDTH);
      end else begin
        width_d = cfg_width;
      end
    end
    if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_FRAME_HEIGHT)) begin
      height_d = (cfg_data_i == '0) ? HEIGHT_W'(1) : cfg_data_i;
    end
  end

  // Input side and frame position.
  assign in_stall_o = (pending_q > OUT_CNT_W'(OUT_DEPTH - 2));
  assign is_flush   = (cmd_i == CMD_FLUSH);
  assign take       = in_valid_i && !in_stall_o && (is_flush == (row_q >= height_q));
  assign col_last   = (col_q == (width_q - WIDTH_W'(1)));
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    ctrl0.flush       = is_flush;
    ctrl0.top_ok      = (row_q >= HEIGHT_W'(2));
    ctrl0.emit_first  = (row_q != '0) && (col_q != '0);
    ctrl0.emit_second = (row_q != '0) && col_last;
    ctrl0.all_cols    = (col_q >= WIDTH_W'(2));
    ctrl0.two_cols    = (col_q != '0);
    n_res             = {1'b0, ctrl0.emit_first} + {1'b0, ctrl0.emit_second};
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    pending_d = pending_q - OUT_CNT_W'(pop);
    if (take) begin
      pending_d = pending_q + OUT_CNT_W'(n_res) - OUT_CNT_W'(pop);
      if (col_last) begin
        col_d = '0;
        row_d = is_flush ? '0 : row_q + HEIGHT_W'(1);
      end else begin
        col_d = col_q + WIDTH_W'(1);
      end
    end
    if (cfg_we) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_W'(W_RST);
      height_q   <= HEIGHT_W'(2048);
      col_q      <= '0;
      row_q      <= '0;
      pending_q  <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
      s2_ctrl_q  <= '0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      pending_q  <= pending_d;
      s1_valid_q <= take;
      s2_valid_q <= s1_valid_q;
      if (take) begin
        s1_ctrl_q <= ctrl0;
      end
      if (s1_valid_q) begin
        s2_ctrl_q <= s1_ctrl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_px_q   <= pixel_i;
      s1_addr_q <= AW'(col_q);
    end
  end

  // Line buffer: read at acceptance, rewritten in the next cycle for pixel beats.
  assign lb_wr_en         = s1_valid_q && !s1_ctrl_q.flush;
  assign lb_wr_data.upper = lb_rd_data.lower;
  assign lb_wr_data.lower = s1_px_q;

  mgr_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (take),
    .rd_addr_i (AW'(col_q)),
    .rd_data_o (lb_rd_data),
    .wr_en_i   (lb_wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (lb_wr_data)
  );

  // Window: three cells, the newest column enters cell 2.
  assign new_col[0] = lb_rd_data.upper;
  assign new_col[1] = lb_rd_data.lower;
  assign new_col[2] = s1_ctrl_q.flush ? PIX_MIN : s1_px_q;

  assign mask.top_ok = s2_ctrl_q.top_ok;
  assign mask.bot_ok = !s2_ctrl_q.flush;

  for (genvar i = 0; i < 3; i++) begin : g_cell
    mgr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_valid_q),
      .col_i   ((i == 2) ? new_col : cell_col[(i + 1) % 3]),
      .mask_i  (mask),
      .col_o   (cell_col[i]),
      .max_o   (cell_max[i]),
      .min_o   (cell_min[i])
    );
  end

  // Gradient over the columns that lie inside the frame.
  always_comb begin
    hi_pair = pix_max(cell_max[1], cell_max[2]);
    lo_pair = pix_min(cell_min[1], cell_min[2]);
    hi_a    = s2_ctrl_q.all_cols ? pix_max(hi_pair, cell_max[0]) : hi_pair;
    lo_a    = s2_ctrl_q.all_cols ? pix_min(lo_pair, cell_min[0]) : lo_pair;
    g1      = hi_a - lo_a;
    g2      = s2_ctrl_q.two_cols ? (hi_pair - lo_pair) : (cell_max[2] - cell_min[2]);

    res_first.gradient      = g1;
    res_first.end_of_frame  = 1'b0;
    res_first.last_of_run   = !s2_ctrl_q.emit_second;
    res_second.gradient     = g2;
    res_second.end_of_frame = s2_ctrl_q.flush;
    res_second.last_of_run  = 1'b1;

    push_first = s2_ctrl_q.emit_first ? res_first : res_second;
    push_n     = s2_valid_q ? ({1'b0, s2_ctrl_q.emit_first} + {1'b0, s2_ctrl_q.emit_second})
                            : 2'd0;
  end

  mgr_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_n_i      (push_n),
    .push_first_i  (push_first),
    .push_second_i (res_second),
    .pop_i         (!out_stall_i),
    .valid_o       (out_valid_o),
    .head_o        (head)
  );

  assign gradient_o     = head.gradient;
  assign end_of_frame_o = head.end_of_frame;
  assign last_of_run_o  = head.last_of_run;

endmodule

// ----- hw/rtl/mgr_checker.sv -----
// Port-level checks for morph_gradient_3x3, bound to every instance of it.
// Sees only the top level's ports; depends on mgr_pkg for port widths.
module mgr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           cmd_i,
  input logic [mgr_pkg::PIX_W-1:0]      pixel_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [mgr_pkg::PIX_W-1:0]      gradient_o,
  input logic                           end_of_frame_o,
  input logic                           last_of_run_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [mgr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [mgr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mgr_pkg::*;

  // A stalled result beat keeps its valid and its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gradient_o) &&
      $stable(end_of_frame_o) && $stable(last_of_run_o))
    else $error("stalled result beat changed");

  // The frame's last result is always the last result of its input beat.
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> last_of_run_o)
    else $error("end of frame without last of run");

  // No result is offered while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // A result that rises on an empty output traces back to an accepted input beat,
  // past the line buffer read, the window shift and the output queue write.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 3))
    else $error("result without a matching input beat");

endmodule

bind morph_gradient_3x3 mgr_checker u_checker (.*);
